[hw/rtl/qpr_pkg.sv]
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared widths, types and pipeline depths for the quaternion point rotator.
// ----------------------------------------------------------------------------
package qpr_pkg;

    localparam int QW         = 16;   // quaternion component, Q1.14
    localparam int PW         = 32;   // coordinate, Q16.16
    localparam int TW         = 36;   // q * p vector, Q16.16 (fits 35 bits signed)
    localparam int NW         = 28;   // normalized conjugate, Q1.26, |n| <= 2^26
    localparam int M2W        = 33;   // squared magnitude, up to 2^32
    localparam int RW         = 31;   // square root, up to 2^30
    localparam int VW         = 62;   // radicand m2 << 28, padded to even width
    localparam int SQRT_STEPS = VW / 2;
    localparam int QTW        = 27;   // quotient bits, |c| * 2^40 / s <= 2^26
    localparam int DIV_STEPS  = QTW;
    localparam int DREM_W     = 31;
    localparam int PRW        = 64;   // t * n products and sums
    localparam int LAT        = 2 + SQRT_STEPS + DIV_STEPS + 2;

    typedef logic signed [QW-1:0] t_quat;
    typedef logic signed [PW-1:0] t_coord;
    typedef logic signed [TW-1:0] t_tval;
    typedef logic signed [NW-1:0] t_nval;

    // component order for mag / neg: 0 = x, 1 = y, 2 = z, 3 = w
    typedef struct packed {
        t_tval                tw;
        t_tval                tx;
        t_tval                ty;
        t_tval                tz;
        logic [3:0][QW-1:0]   mag;
        logic [3:0]           neg;
        logic                 zero;
    } t_side;

    typedef struct packed {
        t_nval nx;
        t_nval ny;
        t_nval nz;
        t_nval nw;
    } t_norm;

endpackage

[hw/rtl/qpr_front.sv]
// ----------------------------------------------------------------------------
// qpr_front
// Two stages: component products, then squared magnitude and t = q * (p, 0).
// ----------------------------------------------------------------------------
module qpr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  qpr_pkg::t_quat         i_quat_x,
    input  qpr_pkg::t_quat         i_quat_y,
    input  qpr_pkg::t_quat         i_quat_z,
    input  qpr_pkg::t_quat         i_quat_w,
    input  qpr_pkg::t_coord        i_point_x,
    input  qpr_pkg::t_coord        i_point_y,
    input  qpr_pkg::t_coord        i_point_z,
    output logic                   o_valid,
    output logic [qpr_pkg::M2W-1:0] o_m2,
    output qpr_pkg::t_side         o_side
);
    import qpr_pkg::*;

    localparam int PPW = QW + PW;      // 48-bit signed products
    localparam int SUW = PPW + 1;

    logic                    r_v1;
    logic signed [PPW-1:0]   r_pp [12];
    logic [2*QW-2:0]         r_sq [4];
    logic [3:0][QW-1:0]      r_mag;
    logic [3:0]              r_neg;

    logic signed [PPW-1:0]   n_pp [12];
    logic [2*QW-2:0]         n_sq [4];
    logic [3:0][QW-1:0]      n_mag;
    logic [3:0]              n_neg;

    logic                    r_v2;
    logic [M2W-1:0]          r_m2;
    t_side                   r_side;
    t_side                   n_side;
    logic [M2W-1:0]          n_m2;

    function automatic t_tval rnd14(input logic signed [SUW-1:0] s);
        logic signed [SUW-1:0] a;
        a = s + SUW'(signed'(1) <<< 13);
        return TW'(a >>> 14);
    endfunction

    function automatic logic [QW-1:0] absq(input t_quat c);
        return c[QW-1] ? QW'(-c) : QW'(c);
    endfunction

    always_comb begin
        logic signed [2*QW-1:0] sq [4];
        t_quat q [4];
        q[0] = i_quat_x; q[1] = i_quat_y; q[2] = i_quat_z; q[3] = i_quat_w;
        for (int k = 0; k < 4; k++) begin
            sq[k]   = (2*QW)'(q[k]) * (2*QW)'(q[k]);
            n_sq[k] = sq[k][2*QW-2:0];
            n_mag[k] = absq(q[k]);
        end
        // conjugate: vector part negated
        n_neg[0] = ~i_quat_x[QW-1] & (i_quat_x != '0);
        n_neg[1] = ~i_quat_y[QW-1] & (i_quat_y != '0);
        n_neg[2] = ~i_quat_z[QW-1] & (i_quat_z != '0);
        n_neg[3] = i_quat_w[QW-1];
        n_pp[0]  = PPW'(i_quat_x) * PPW'(i_point_x);
        n_pp[1]  = PPW'(i_quat_y) * PPW'(i_point_y);
        n_pp[2]  = PPW'(i_quat_z) * PPW'(i_point_z);
        n_pp[3]  = PPW'(i_quat_w) * PPW'(i_point_x);
        n_pp[4]  = PPW'(i_quat_y) * PPW'(i_point_z);
        n_pp[5]  = PPW'(i_quat_z) * PPW'(i_point_y);
        n_pp[6]  = PPW'(i_quat_w) * PPW'(i_point_y);
        n_pp[7]  = PPW'(i_quat_z) * PPW'(i_point_x);
        n_pp[8]  = PPW'(i_quat_x) * PPW'(i_point_z);
        n_pp[9]  = PPW'(i_quat_w) * PPW'(i_point_z);
        n_pp[10] = PPW'(i_quat_x) * PPW'(i_point_y);
        n_pp[11] = PPW'(i_quat_y) * PPW'(i_point_x);
    end

    always_comb begin
        n_m2 = M2W'(r_sq[0]) + M2W'(r_sq[1]) + M2W'(r_sq[2]) + M2W'(r_sq[3]);
        n_side.tw   = rnd14(-SUW'(r_pp[0]) - SUW'(r_pp[1]) - SUW'(r_pp[2]));
        n_side.tx   = rnd14(SUW'(r_pp[3]) + SUW'(r_pp[4]) - SUW'(r_pp[5]));
        n_side.ty   = rnd14(SUW'(r_pp[6]) + SUW'(r_pp[7]) - SUW'(r_pp[8]));
        n_side.tz   = rnd14(SUW'(r_pp[9]) + SUW'(r_pp[10]) - SUW'(r_pp[11]));
        n_side.mag  = r_mag;
        n_side.neg  = r_neg;
        n_side.zero = (n_m2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_pp   <= n_pp;
        r_sq   <= n_sq;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_m2   <= n_m2;
        r_side <= n_side;
    end

    assign o_valid = r_v2;
    assign o_m2    = r_m2;
    assign o_side  = r_side;

endmodule

[hw/rtl/qpr_isqrt.sv]
// ----------------------------------------------------------------------------
// qpr_isqrt
// Pipelined integer square root of m2 << 28, one result bit per stage.
// ----------------------------------------------------------------------------
module qpr_isqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [qpr_pkg::M2W-1:0] i_m2,
    input  qpr_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic [qpr_pkg::RW-1:0]  o_root,
    output qpr_pkg::t_side          o_side
);
    import qpr_pkg::*;

    localparam int N    = SQRT_STEPS;
    localparam int REMW = RW + 3;

    logic            w_vld  [0:N];
    logic [REMW-1:0] w_rem  [0:N];
    logic [RW-1:0]   w_root [0:N];
    logic [VW-1:0]   w_rad  [0:N];
    t_side           w_side [0:N];

    logic            r_vld  [1:N];
    logic [REMW-1:0] r_rem  [1:N];
    logic [RW-1:0]   r_root [1:N];
    logic [VW-1:0]   r_rad  [1:N];
    t_side           r_side [1:N];

    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = {1'b0, i_m2, 28'b0};
    assign w_side[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [REMW-1:0] n_rem2;
        logic [REMW-1:0] n_trial;
        logic            n_ge;

        assign n_rem2  = {w_rem[k][REMW-3:0], w_rad[k][VW-1 -: 2]};
        assign n_trial = {1'b0, w_root[k], 2'b01};
        assign n_ge    = (n_rem2 >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= w_vld[k];
            end
            r_rem[k+1]  <= n_ge ? n_rem2 - n_trial : n_rem2;
            r_root[k+1] <= {w_root[k][RW-2:0], n_ge};
            r_rad[k+1]  <= {w_rad[k][VW-3:0], 2'b00};
            r_side[k+1] <= w_side[k];
        end

        assign w_vld[k+1]  = r_vld[k+1];
        assign w_rem[k+1]  = r_rem[k+1];
        assign w_root[k+1] = r_root[k+1];
        assign w_rad[k+1]  = r_rad[k+1];
        assign w_side[k+1] = r_side[k+1];
    end

    assign o_valid = w_vld[N];
    assign o_root  = w_root[N];
    assign o_side  = w_side[N];

endmodule

[hw/rtl/qpr_div.sv]
// ----------------------------------------------------------------------------
// qpr_div
// Four restoring dividers in lockstep: |c| * 2^40 / s, one quotient bit
// per stage, sign reapplied at the end.
// ----------------------------------------------------------------------------
module qpr_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [qpr_pkg::RW-1:0] i_root,
    input  qpr_pkg::t_side         i_side,
    output logic                   o_valid,
    output qpr_pkg::t_norm         o_norm,
    output qpr_pkg::t_side         o_side
);
    import qpr_pkg::*;

    localparam int N = DIV_STEPS;

    logic                     w_vld  [0:N];
    logic [3:0][DREM_W-1:0]   w_rem  [0:N];
    logic [3:0][QTW-1:0]      w_quo  [0:N];
    logic [RW-1:0]            w_div  [0:N];
    t_side                    w_side [0:N];

    logic                     r_vld  [1:N];
    logic [3:0][DREM_W-1:0]   r_rem  [1:N];
    logic [3:0][QTW-1:0]      r_quo  [1:N];
    logic [RW-1:0]            r_div  [1:N];
    t_side                    r_side [1:N];

    logic [NW-1:0]            n_n [4];

    assign w_vld[0]  = i_valid;
    assign w_div[0]  = i_root;
    assign w_side[0] = i_side;
    // upper dividend bits are |c| << 13; for a nonzero quaternion they are below the divisor
    for (genvar c = 0; c < 4; c++) begin : g_init
        assign w_rem[0][c] = {2'b00, i_side.mag[c], 13'b0};
        assign w_quo[0][c] = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [3:0][DREM_W-1:0] n_rem;
        logic [3:0][QTW-1:0]    n_quo;

        always_comb begin
            logic [DREM_W-1:0] sh;
            for (int c = 0; c < 4; c++) begin
                sh = {w_rem[k][c][DREM_W-2:0], 1'b0};
                if (sh >= DREM_W'(w_div[k])) begin
                    n_rem[c] = sh - DREM_W'(w_div[k]);
                    n_quo[c] = {w_quo[k][c][QTW-2:0], 1'b1};
                end else begin
                    n_rem[c] = sh;
                    n_quo[c] = {w_quo[k][c][QTW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= w_vld[k];
            end
            r_rem[k+1]  <= n_rem;
            r_quo[k+1]  <= n_quo;
            r_div[k+1]  <= w_div[k];
            r_side[k+1] <= w_side[k];
        end

        assign w_vld[k+1]  = r_vld[k+1];
        assign w_rem[k+1]  = r_rem[k+1];
        assign w_quo[k+1]  = r_quo[k+1];
        assign w_div[k+1]  = r_div[k+1];
        assign w_side[k+1] = r_side[k+1];
    end

    // zero quaternion: root is zero, quotient is meaningless, force n = 0
    always_comb begin
        logic [NW-1:0] q;
        for (int c = 0; c < 4; c++) begin
            q = NW'(w_quo[N][c]);
            if (w_side[N].zero) begin
                n_n[c] = '0;
            end else if (w_side[N].neg[c]) begin
                n_n[c] = -q;
            end else begin
                n_n[c] = q;
            end
        end
    end

    assign o_valid   = w_vld[N];
    assign o_norm.nx = n_n[0];
    assign o_norm.ny = n_n[1];
    assign o_norm.nz = n_n[2];
    assign o_norm.nw = n_n[3];
    assign o_side    = w_side[N];

endmodule

[hw/rtl/qpr_back.sv]
// ----------------------------------------------------------------------------
// qpr_back
// r = t * n vector part: products stage, then sum, round and saturate.
// ----------------------------------------------------------------------------
module qpr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  qpr_pkg::t_side  i_side,
    input  qpr_pkg::t_norm  i_norm,
    output logic            o_valid,
    output qpr_pkg::t_coord o_rotated_x,
    output qpr_pkg::t_coord o_rotated_y,
    output qpr_pkg::t_coord o_rotated_z
);
    import qpr_pkg::*;

    logic                  r_v1;
    logic signed [PRW-1:0] r_pr [12];
    logic signed [PRW-1:0] n_pr [12];
    logic                  r_v2;
    t_coord                r_rx, r_ry, r_rz;
    t_coord                n_rx, n_ry, n_rz;

    function automatic t_coord rnd_sat(input logic signed [PRW-1:0] s);
        logic signed [PRW-1:0] a;
        a = (s + PRW'(signed'(1) <<< 25)) >>> 26;
        if (a > PRW'(signed'(32'sh7fffffff))) begin
            return 32'sh7fffffff;
        end else if (a < PRW'(signed'(32'sh80000000))) begin
            return 32'sh80000000;
        end else begin
            return PW'(a);
        end
    endfunction

    always_comb begin
        n_pr[0]  = PRW'(i_side.tw) * PRW'(i_norm.nx);
        n_pr[1]  = PRW'(i_side.tx) * PRW'(i_norm.nw);
        n_pr[2]  = PRW'(i_side.ty) * PRW'(i_norm.nz);
        n_pr[3]  = PRW'(i_side.tz) * PRW'(i_norm.ny);
        n_pr[4]  = PRW'(i_side.tw) * PRW'(i_norm.ny);
        n_pr[5]  = PRW'(i_side.ty) * PRW'(i_norm.nw);
        n_pr[6]  = PRW'(i_side.tz) * PRW'(i_norm.nx);
        n_pr[7]  = PRW'(i_side.tx) * PRW'(i_norm.nz);
        n_pr[8]  = PRW'(i_side.tw) * PRW'(i_norm.nz);
        n_pr[9]  = PRW'(i_side.tz) * PRW'(i_norm.nw);
        n_pr[10] = PRW'(i_side.tx) * PRW'(i_norm.ny);
        n_pr[11] = PRW'(i_side.ty) * PRW'(i_norm.nx);
    end

    always_comb begin
        n_rx = rnd_sat(r_pr[0] + r_pr[1] + r_pr[2] - r_pr[3]);
        n_ry = rnd_sat(r_pr[4] + r_pr[5] + r_pr[6] - r_pr[7]);
        n_rz = rnd_sat(r_pr[8] + r_pr[9] + r_pr[10] - r_pr[11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_pr <= n_pr;
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_rz <= n_rz;
    end

    assign o_valid     = r_v2;
    assign o_rotated_x = r_rx;
    assign o_rotated_y = r_ry;
    assign o_rotated_z = r_rz;

endmodule

[hw/rtl/quaternion_point_rotate.sv]
// ----------------------------------------------------------------------------
// quaternion_point_rotate
// Rotates a Q16.16 point by a Q1.14 quaternion, r = q * p * conj(q)/|q|.
// ----------------------------------------------------------------------------
// Usage:
//   An item (quaternion and point) is taken on every clock edge where start
//   is high and busy is low. busy never rises, so one item per cycle is
//   taken without gaps.
//   The result appears on o_rotated_* for exactly one cycle, flagged by
//   o_valid, in the order taken.
//   Pipeline: products and sums, then square root (one result bit per
//   stage), then division (one quotient bit per stage), then final
//   products, rounding and saturation.
//   Throughput: one item per cycle, sustained.
//   A zero quaternion gives a zero result; out-of-range results clamp to
//   the 32-bit limits.
//   Reset (synchronous, active low) drops every item in flight; no result
//   appears for items taken before it. The receiver cannot stall, so there
//   is no back-pressure path.
// ----------------------------------------------------------------------------
module quaternion_point_rotate (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  qpr_pkg::t_quat  i_quat_x,
    input  qpr_pkg::t_quat  i_quat_y,
    input  qpr_pkg::t_quat  i_quat_z,
    input  qpr_pkg::t_quat  i_quat_w,
    input  qpr_pkg::t_coord i_point_x,
    input  qpr_pkg::t_coord i_point_y,
    input  qpr_pkg::t_coord i_point_z,
    output logic            o_valid,
    output qpr_pkg::t_coord o_rotated_x,
    output qpr_pkg::t_coord o_rotated_y,
    output qpr_pkg::t_coord o_rotated_z
);
    import qpr_pkg::*;

    logic           fr_valid;
    logic [M2W-1:0] fr_m2;
    t_side          fr_side;
    logic           sq_valid;
    logic [RW-1:0]  sq_root;
    t_side          sq_side;
    logic           dv_valid;
    t_norm          dv_norm;
    t_side          dv_side;

    assign busy = 1'b0;

    qpr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start & ~busy),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_valid   (fr_valid),
        .o_m2      (fr_m2),
        .o_side    (fr_side)
    );

    qpr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_m2    (fr_m2),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    qpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_norm  (dv_norm),
        .o_side  (dv_side)
    );

    qpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_valid),
        .i_side      (dv_side),
        .i_norm      (dv_norm),
        .o_valid     (o_valid),
        .o_rotated_x (o_rotated_x),
        .o_rotated_y (o_rotated_y),
        .o_rotated_z (o_rotated_z)
    );

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a matching item");

    a_zero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_quat_x == '0 && i_quat_y == '0 && i_quat_z == '0
                         && i_quat_w == '0, LAT)
        |-> (o_rotated_x == '0 && o_rotated_y == '0 && o_rotated_z == '0))
        else $error("zero quaternion gave nonzero result");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion point rotator: directed corner items
// then random quaternion/point items, predicted in the bench and compared.
// ----------------------------------------------------------------------------
module tb_top;
    import qpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 1600;

    typedef struct {
        t_quat  qx, qy, qz, qw;
        t_coord px, py, pz;
    } t_item;

    typedef struct {
        t_coord rx, ry, rz;
    } t_rot;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_quat  i_quat_x = '0, i_quat_y = '0, i_quat_z = '0, i_quat_w = '0;
    t_coord i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic   o_valid;
    t_coord o_rotated_x, o_rotated_y, o_rotated_z;

    t_item pending_items[$];
    t_rot  expected_rot[$];
    int    errors = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    idle_cnt = 0;
    int    gap_left = 0;
    bit    gaps_on = 1'b1;
    bit    hold_off = 1'b0;
    bit    stim_done = 1'b0;

    quaternion_point_rotate dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint rnd_sh(longint x, int k);
        return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint norm_of(longint c, longint s);
        longint unsigned mag;
        longint q;
        mag = (c < 0) ? longint'(-c) : c;
        q = longint'((mag << 40) / longint'(s));
        return (c < 0) ? -q : q;
    endfunction

    function automatic t_coord clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_coord'(v);
    endfunction

    function automatic t_rot rotate_point(t_item it);
        longint qx, qy, qz, qw, px, py, pz, s;
        longint nx, ny, nz, nw, tx, ty, tz, tw, rx, ry, rz;
        longint unsigned m2;
        t_rot r;
        qx = it.qx; qy = it.qy; qz = it.qz; qw = it.qw;
        px = it.px; py = it.py; pz = it.pz;
        m2 = qx*qx + qy*qy + qz*qz + qw*qw;
        nx = 0; ny = 0; nz = 0; nw = 0;
        if (m2 > 0) begin
            s  = int_sqrt(m2 << 28);
            nx = norm_of(-qx, s);
            ny = norm_of(-qy, s);
            nz = norm_of(-qz, s);
            nw = norm_of(qw, s);
        end
        tw = rnd_sh(-(qx*px) - (qy*py) - (qz*pz), 14);
        tx = rnd_sh((qw*px) + (qy*pz) - (qz*py), 14);
        ty = rnd_sh((qw*py) + (qz*px) - (qx*pz), 14);
        tz = rnd_sh((qw*pz) + (qx*py) - (qy*px), 14);
        rx = tw*nx + tx*nw + ty*nz - tz*ny;
        ry = tw*ny + ty*nw + tz*nx - tx*nz;
        rz = tw*nz + tz*nw + tx*ny - ty*nx;
        r.rx = clamp32(rnd_sh(rx, 26));
        r.ry = clamp32(rnd_sh(ry, 26));
        r.rz = clamp32(rnd_sh(rz, 26));
        return r;
    endfunction

    function automatic t_item mk(int qx, int qy, int qz, int qw, int px, int py, int pz);
        t_item it;
        it.qx = t_quat'(qx); it.qy = t_quat'(qy); it.qz = t_quat'(qz); it.qw = t_quat'(qw);
        it.px = px; it.py = py; it.pz = pz;
        return it;
    endfunction

    // small values often, full-range values sometimes
    function automatic t_quat rand_quat();
        case ($urandom_range(3))
            0: return t_quat'($urandom);
            1: return t_quat'($urandom_range(16384) - 8192);
            2: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
            default: return t_quat'($urandom_range(32767) - 16384);
        endcase
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(3))
            0: return t_coord'($urandom);
            1: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return t_coord'($urandom_range(32'h01ff_ffff)) - 32'sh0100_0000;
        endcase
    endfunction

    initial begin
        t_item it;
        pending_items.push_back(mk(0, 0, 0, 0, 12345, -6789, 32'h7fffffff));
        pending_items.push_back(mk(0, 0, 0, 16384, 65536, 131072, -65536));
        pending_items.push_back(mk(16384, 0, 0, 0, 65536, 65536, 65536));
        pending_items.push_back(mk(0, 16384, 0, 0, 65536, -65536, 65536));
        pending_items.push_back(mk(0, 0, 16384, 0, 65536, 65536, -65536));
        pending_items.push_back(mk(11585, 0, 0, 11585, 0, 65536, 0));
        pending_items.push_back(mk(32767, 32767, 32767, 32767,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_items.push_back(mk(-32768, -32768, -32768, -32768,
                                   32'h80000000, 32'h80000000, 32'h80000000));
        pending_items.push_back(mk(-32768, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0));
        pending_items.push_back(mk(0, 0, 0, -32768, 32'h7fffffff, 32'h80000000, -1));
        pending_items.push_back(mk(1, 0, 0, 0, -1, 1, -1));
        pending_items.push_back(mk(0, 0, 0, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        pending_items.push_back(mk(32767, -32768, 32767, -32768,
                                   32'h7fffffff, 32'h80000000, 32'h7fffffff));
        pending_items.push_back(mk(-1, -1, -1, -1, -1, -1, -1));
        pending_items.push_back(mk(16384, 16384, 16384, 16384, 0, 0, 0));
        for (int i = 0; i < N_RANDOM; i++) begin
            it.qx = rand_quat(); it.qy = rand_quat(); it.qz = rand_quat(); it.qw = rand_quat();
            if ($urandom_range(40) == 0) begin
                it.qx = 0; it.qy = 0; it.qz = 0; it.qw = 0;
            end
            it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
            pending_items.push_back(it);
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy && n_sent == 600)
                hold_off <= 1'b1;
            if (hold_off) begin
                start <= 1'b0;
                if (expected_rot.size() == 0) hold_off <= 1'b0;
            end else if (start && busy) begin
                // item not taken yet, keep it up
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                if (pending_items.size() < 200) gaps_on <= 1'b0;
                if (gaps_on && $urandom_range(9) == 0) begin
                    start <= 1'b0;
                    gap_left <= $urandom_range(14);
                end else begin
                    start     <= 1'b1;
                    i_quat_x  <= pending_items[0].qx;
                    i_quat_y  <= pending_items[0].qy;
                    i_quat_z  <= pending_items[0].qz;
                    i_quat_w  <= pending_items[0].qw;
                    i_point_x <= pending_items[0].px;
                    i_point_y <= pending_items[0].py;
                    i_point_z <= pending_items[0].pz;
                    pending_items.pop_front();
                end
            end else begin
                start <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // monitor: accepts items and checks results at the rising edge
    always @(posedge i_clk) begin
        t_item it;
        t_rot  got, exp_r;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (start && !busy) begin
                it.qx = i_quat_x; it.qy = i_quat_y; it.qz = i_quat_z; it.qw = i_quat_w;
                it.px = i_point_x; it.py = i_point_y; it.pz = i_point_z;
                expected_rot.push_back(rotate_point(it));
                n_sent <= n_sent + 1;
            end
            if (o_valid) begin
                got.rx = o_rotated_x; got.ry = o_rotated_y; got.rz = o_rotated_z;
                if (expected_rot.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d",
                             $time, got.rx, got.ry, got.rz);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_rot.pop_front();
                    if (got.rx !== exp_r.rx || got.ry !== exp_r.ry || got.rz !== exp_r.rz) begin
                        $display("%0t: mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 $time, exp_r.rx, exp_r.ry, exp_r.rz,
                                 got.rx, got.ry, got.rz);
                        errors <= errors + 1;
                    end
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    initial begin
        wait (stim_done && expected_rot.size() == 0);
        repeat (LAT + 10) @(posedge i_clk);
        $display("Covered %0d items (zero and extreme quaternions, saturating points),",
                 n_sent);
        $display("%0d rotated points checked, %0d errors.", n_checked, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        wait (idle_cnt >= WATCHDOG_LIMIT);
        $display("Watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
